/* design/fdmcw_pkg.sv */
// ----------------------------------------------------------------------------
// fdmcw_pkg
// Types, codes and helper functions for the framed dual motor command
// decoder with its command watchdog.
// ----------------------------------------------------------------------------
package fdmcw_pkg;

    localparam logic [7:0]  HDR_FIRST     = 8'hAA;
    localparam logic [7:0]  HDR_SECOND    = 8'h55;
    localparam logic [15:0] TIMEOUT_RESET = 16'd500;
    localparam logic [15:0] IDLE_MAX      = 16'hFFFF;
    localparam logic [6:0]  DRIVE_LIMIT   = 7'd100;
    // ceil(2^21 / 100): exact floor division by 100 for values below 2^21/48
    localparam int          RECIP_SHIFT   = 21;
    localparam logic [14:0] RECIP_100     = 15'd20972;

    // item kind codes
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // result cause codes
    localparam logic CAUSE_FRAME    = 1'b0;
    localparam logic CAUSE_WATCHDOG = 1'b1;

    // bridge direction codes
    localparam logic [1:0] DIR_BRAKE   = 2'd0;
    localparam logic [1:0] DIR_FORWARD = 2'd1;
    localparam logic [1:0] DIR_REVERSE = 2'd2;

    typedef struct packed {
        logic       kind;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic [1:0] left_direction;
        logic [7:0] left_duty;
        logic [1:0] right_direction;
        logic [7:0] right_duty;
        logic       drive_active;
        logic       cause;
    } t_out_item;

    typedef struct packed {
        logic [1:0] direction;
        logic [7:0] duty;
    } t_wheel;

    // mag * 255 / 100, floored; mag is at most 100
    function automatic logic [7:0] f_duty(input logic [6:0] mag);
        logic [14:0] scaled;
        logic [29:0] prod;
        scaled = {mag, 8'd0} - {8'd0, mag};
        prod   = 30'(scaled) * 30'(RECIP_100);
        return prod[RECIP_SHIFT+7:RECIP_SHIFT];
    endfunction

    // clamp a signed drive value and form direction and duty
    function automatic t_wheel f_wheel(input logic [15:0] raw);
        logic signed [15:0] v;
        logic        [15:0] neg;
        logic        [6:0]  mag;
        t_wheel             w;
        v   = $signed(raw);
        neg = 16'(-v);
        if (v > 16'sd100) begin
            w.direction = DIR_FORWARD;
            mag         = DRIVE_LIMIT;
        end else if (v < -16'sd100) begin
            w.direction = DIR_REVERSE;
            mag         = DRIVE_LIMIT;
        end else if (v > 16'sd0) begin
            w.direction = DIR_FORWARD;
            mag         = raw[6:0];
        end else if (v < 16'sd0) begin
            w.direction = DIR_REVERSE;
            mag         = neg[6:0];
        end else begin
            w.direction = DIR_BRAKE;
            mag         = 7'd0;
        end
        w.duty = f_duty(mag);
        return w;
    endfunction

endpackage

/* design/framed_dual_motor_command_watchdog.sv */
// ----------------------------------------------------------------------------
// framed_dual_motor_command_watchdog
// Decodes framed two-wheel drive commands from a byte stream and stops the
// drive when no frame arrives within the watchdog timeout.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data): one transaction is
//   either a received byte (kind 0) or a one millisecond tick (kind 1).
//   Frames are 0xAA, 0x55, then left and right signed 16-bit little-endian
//   drive values. The last frame byte yields a command result; a tick that
//   pushes the idle count past the timeout while active yields an all-stop.
//   Output channel (o_out_valid / i_out_stall / o_out_data): one transaction
//   per result; items that cause no result produce nothing.
//   Config channel (i_cfg_valid / o_cfg_ready / i_cfg_data): watchdog timeout
//   in ticks; always ready, write only while the block is idle.
//   Throughput: one item per cycle while no stall holds the result register.
//   Path: an accepted item enters the input register, then its result enters
//   the result register; clamp, scale and watchdog compare sit between them.
//   Stall: a stalled result holds in the result register; the input register
//   holds its item and o_in_stall rises while it holds an item and the result
//   register is full and stalled.
//   Reset (synchronous, active low): frame search restarts, idle count and
//   active flag clear, timeout returns to 500, both registers empty.
// ----------------------------------------------------------------------------
module framed_dual_motor_command_watchdog (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  fdmcw_pkg::t_in_item   i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output fdmcw_pkg::t_out_item  o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [15:0]           i_cfg_data
);

    typedef enum logic [5:0] {
        POS_HDR1 = 6'b000001,
        POS_HDR2 = 6'b000010,
        POS_PAY0 = 6'b000100,
        POS_PAY1 = 6'b001000,
        POS_PAY2 = 6'b010000,
        POS_PAY3 = 6'b100000
    } t_pos;

    t_pos                 r_pos, n_pos;
    logic [15:0]          r_timeout;
    logic [15:0]          r_idle, n_idle;
    logic                 r_active, n_active;
    logic [7:0]           r_pay0, r_pay1, r_pay2;
    logic                 r_s1_valid;
    fdmcw_pkg::t_in_item  r_s1_item;
    logic                 r_out_valid, n_out_valid;
    fdmcw_pkg::t_out_item r_out_data, n_out_data;

    logic                 out_free;
    logic                 step;
    logic [15:0]          idle_inc;
    fdmcw_pkg::t_wheel    left_w, right_w;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign step        = r_s1_valid && out_free;
    assign o_in_stall  = r_s1_valid && !out_free;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_cfg_ready = 1'b1;

    assign idle_inc = (r_idle == fdmcw_pkg::IDLE_MAX) ? r_idle : r_idle + 16'd1;
    assign left_w   = fdmcw_pkg::f_wheel({r_pay1, r_pay0});
    assign right_w  = fdmcw_pkg::f_wheel({r_s1_item.rx_byte, r_pay2});

    always_comb begin
        n_pos       = r_pos;
        n_idle      = r_idle;
        n_active    = r_active;
        n_out_valid = 1'b0;
        n_out_data  = '0;
        if (r_s1_item.kind == fdmcw_pkg::KIND_TICK) begin
            n_idle = idle_inc;
            if (r_active && (idle_inc > r_timeout)) begin
                n_active              = 1'b0;
                n_out_valid           = 1'b1;
                n_out_data.cause      = fdmcw_pkg::CAUSE_WATCHDOG;
                n_out_data.left_direction  = fdmcw_pkg::DIR_BRAKE;
                n_out_data.right_direction = fdmcw_pkg::DIR_BRAKE;
            end
        end else begin
            unique case (r_pos)
                POS_HDR1: begin
                    n_pos = (r_s1_item.rx_byte == fdmcw_pkg::HDR_FIRST) ? POS_HDR2 : POS_HDR1;
                end
                POS_HDR2: begin
                    // any other byte, even a first header, restarts the search
                    n_pos = (r_s1_item.rx_byte == fdmcw_pkg::HDR_SECOND) ? POS_PAY0 : POS_HDR1;
                end
                POS_PAY0: n_pos = POS_PAY1;
                POS_PAY1: n_pos = POS_PAY2;
                POS_PAY2: n_pos = POS_PAY3;
                POS_PAY3: begin
                    n_pos                      = POS_HDR1;
                    n_idle                     = 16'd0;
                    n_active                   = 1'b1;
                    n_out_valid                = 1'b1;
                    n_out_data.left_direction  = left_w.direction;
                    n_out_data.left_duty       = left_w.duty;
                    n_out_data.right_direction = right_w.direction;
                    n_out_data.right_duty      = right_w.duty;
                    n_out_data.drive_active    = 1'b1;
                    n_out_data.cause           = fdmcw_pkg::CAUSE_FRAME;
                end
                default: n_pos = POS_HDR1;
            endcase
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= POS_HDR1;
            r_timeout   <= fdmcw_pkg::TIMEOUT_RESET;
            r_idle      <= 16'd0;
            r_active    <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_timeout <= i_cfg_data;
            end
            if (step) begin
                r_pos    <= n_pos;
                r_idle   <= n_idle;
                r_active <= n_active;
            end
            if (!o_in_stall) begin
                r_s1_valid <= i_in_valid;
            end
            if (out_free) begin
                r_out_valid <= step && n_out_valid;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_s1_item <= i_in_data;
        end
        if (step && (r_s1_item.kind == fdmcw_pkg::KIND_BYTE)) begin
            if (r_pos == POS_PAY0) begin
                r_pay0 <= r_s1_item.rx_byte;
            end
            if (r_pos == POS_PAY1) begin
                r_pay1 <= r_s1_item.rx_byte;
            end
            if (r_pos == POS_PAY2) begin
                r_pay2 <= r_s1_item.rx_byte;
            end
        end
        if (step && n_out_valid) begin
            r_out_data <= n_out_data;
        end
    end

endmodule

/* design/fdmcw_checker.sv */
// ----------------------------------------------------------------------------
// fdmcw_checker
// Port-level checks for the framed dual motor command watchdog.
// ----------------------------------------------------------------------------
module fdmcw_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input fdmcw_pkg::t_out_item o_out_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    // a watchdog stop drives both bridges to brake with zero duty
    a_stop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.cause == fdmcw_pkg::CAUSE_WATCHDOG) |->
        (o_out_data.left_direction == fdmcw_pkg::DIR_BRAKE) &&
        (o_out_data.right_direction == fdmcw_pkg::DIR_BRAKE) &&
        (o_out_data.left_duty == 8'd0) && (o_out_data.right_duty == 8'd0) &&
        !o_out_data.drive_active)
        else $error("watchdog stop with drive fields set");

    // a command frame always marks the drive active
    a_frame_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.cause == fdmcw_pkg::CAUSE_FRAME) |->
        o_out_data.drive_active)
        else $error("command frame without active drive");

    // brake exactly when duty is zero, per wheel
    a_brake_duty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
        ((o_out_data.left_direction == fdmcw_pkg::DIR_BRAKE) ==
         (o_out_data.left_duty == 8'd0)) &&
        ((o_out_data.right_direction == fdmcw_pkg::DIR_BRAKE) ==
         (o_out_data.right_duty == 8'd0)))
        else $error("direction and duty disagree");

endmodule

bind framed_dual_motor_command_watchdog fdmcw_checker u_fdmcw_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
